FILE: rtl/spa_pkg.sv
// Shared types and constants for the slot pool allocator.
// Used by every module under rtl; depends on nothing else.
package spa_pkg;

	localparam int OFS_W     = 18;  // byte offset fields
	localparam int IDX_W     = 10;  // slot index field and free stack entries
	localparam int SLOT_W    = 11;  // internal slot index, wide enough for any pool size
	localparam int OCT_W     = 9;   // element size register
	localparam int POOL_W    = 11;  // pool size register
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 11;
	localparam int STEP_W    = $clog2(OFS_W);

	localparam logic [STEP_W-1:0]    STEP_LAST   = STEP_W'(OFS_W - 1);
	localparam logic [CFG_IDX_W-1:0] REG_POOL_ENTRIES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_OCTETS = 2'd1;
	localparam logic [POOL_W-1:0]    POOL_RESET  = 11'd1024;
	localparam logic [OCT_W-1:0]     OCT_RESET   = 9'd1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_RANGE     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		logic              is_free;
		logic              range_err;
		logic [SLOT_W-1:0] idx;
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_LIMIT,
		F_CHECK,
		F_DIV,
		F_SEND
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_MUL
	} back_state_t;

endpackage

FILE: rtl/spa_front.sv
// Front end: accepts request words, range checks free offsets and divides them
// down to a slot index. Depends on spa_pkg.
module spa_front #(
	parameter int CNT_W = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        req_type,
	input  logic [spa_pkg::OFS_W-1:0]   byte_offset,
	input  logic [CNT_W-1:0]            eff_pool,
	input  logic [spa_pkg::OCT_W-1:0]   eff_oct,
	output logic                        q_push,
	output spa_pkg::cmd_t               q_cmd,
	input  logic                        q_full
);
	import spa_pkg::*;

	localparam int PROD_W = CNT_W + OCT_W;
	localparam int CMP_W  = PROD_W + OFS_W;

	front_state_t        state_q, state_d;
	logic                free_q;
	logic                range_q;
	logic [OFS_W-1:0]    off_q;
	logic [OCT_W-1:0]    rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [PROD_W-1:0]   limit_q;
	logic                off_ge;
	logic [OCT_W:0]      trial;
	logic [OCT_W:0]      diff;
	logic                take;
	logic [OCT_W-1:0]    rem_nxt;

	assign off_ge  = CMP_W'(off_q) >= CMP_W'(limit_q);

	// One quotient bit per cycle: shift the next dividend bit into the remainder.
	assign trial   = {rem_q, off_q[OFS_W-1]};
	assign diff    = trial - {1'b0, eff_oct};
	assign take    = trial >= {1'b0, eff_oct};
	assign rem_nxt = take ? diff[OCT_W-1:0] : trial[OCT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_push  = 1'b0;
		full    = 1'b1;
		unique case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (push) begin
					state_d = (req_type == REQ_FREE) ? F_LIMIT : F_SEND;
				end
			end
			F_LIMIT: begin
				state_d = F_CHECK;
			end
			F_CHECK: begin
				state_d = off_ge ? F_SEND : F_DIV;
			end
			F_DIV: begin
				if (step_q == STEP_LAST) begin
					state_d = F_SEND;
				end
			end
			F_SEND: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// The offset register doubles as the dividend and then the quotient.
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (push) begin
					off_q   <= byte_offset;
					free_q  <= (req_type == REQ_FREE);
					range_q <= 1'b0;
				end
			end
			F_LIMIT: begin
				limit_q <= PROD_W'(eff_pool) * PROD_W'(eff_oct);
			end
			F_CHECK: begin
				range_q <= off_ge;
				rem_q   <= '0;
				step_q  <= '0;
			end
			F_DIV: begin
				rem_q  <= rem_nxt;
				off_q  <= {off_q[OFS_W-2:0], take};
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign q_cmd.is_free   = free_q;
	assign q_cmd.range_err = range_q;
	assign q_cmd.idx       = off_q[SLOT_W-1:0];

	a_div_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV) |-> (step_q <= STEP_LAST))
		else $error("divider ran past its last step");

endmodule

FILE: rtl/spa_cmd_queue.sv
// Two-word queue that decouples the front end from the back end.
// Depends on spa_pkg for the command word type.
module spa_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  spa_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output spa_pkg::cmd_t rd_data,
	output logic          empty
);
	import spa_pkg::*;

	cmd_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("command queue count out of range");

endmodule

FILE: rtl/spa_back.sv
// Back end: owns the free stack memory and the counters, carries out each
// command and holds the result word. Depends on spa_pkg.
module spa_back #(
	parameter int POOL_CAP = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  spa_pkg::cmd_t                          q_cmd,
	input  logic                                   q_empty,
	output logic                                   q_pop,
	input  logic [$clog2(POOL_CAP+1)-1:0]          eff_pool,
	input  logic [spa_pkg::OCT_W-1:0]              eff_oct,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [1:0]                             status,
	output logic [spa_pkg::IDX_W-1:0]              slot_index,
	output logic [spa_pkg::OFS_W-1:0]              slot_byte_offset,
	output logic                                   reused
);
	import spa_pkg::*;

	localparam int CNT_W = $clog2(POOL_CAP + 1);
	localparam int AW    = $clog2(POOL_CAP);
	localparam int PRD_W = SLOT_W + OCT_W;

	logic [IDX_W-1:0]  stack_mem [POOL_CAP];
	logic [IDX_W-1:0]  rd_data_q;

	back_state_t       state_q, state_d;
	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  high_water_q;
	logic [CNT_W-1:0]  count_dec;
	status_t           st_q;
	logic [SLOT_W-1:0] idx_q;
	logic              reused_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [OFS_W-1:0]  out_ofs_q;
	logic              out_reused_q;

	logic              mem_rd;
	logic              mem_wr;
	logic              take_new;
	logic              exhausted;
	logic              stack_full;
	logic              load;
	logic [PRD_W-1:0]  product;

	assign count_dec  = free_count_q - 1'b1;
	assign stack_full = (free_count_q >= eff_pool);
	assign product    = PRD_W'(idx_q) * PRD_W'(eff_oct);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_rd    = 1'b0;
		mem_wr    = 1'b0;
		take_new  = 1'b0;
		exhausted = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_MUL;
					if (!q_cmd.is_free) begin
						if (free_count_q != '0) begin
							mem_rd  = 1'b1;
							state_d = B_READ;
						end else if (high_water_q < eff_pool) begin
							take_new = 1'b1;
						end else begin
							exhausted = 1'b1;
						end
					end else if (!q_cmd.range_err && !stack_full) begin
						mem_wr = 1'b1;
					end
				end
			end
			B_READ: begin
				state_d = B_MUL;
			end
			B_MUL: begin
				if (!out_valid_q || pop) begin
					load    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Free stack: one write or one registered read per cycle, no reset.
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			stack_mem[free_count_q[AW-1:0]] <= q_cmd.idx[IDX_W-1:0];
		end
		if (mem_rd) begin
			rd_data_q <= stack_mem[count_dec[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= '0;
			high_water_q <= '0;
		end else begin
			if (mem_rd) begin
				free_count_q <= count_dec;
			end else if (mem_wr) begin
				free_count_q <= free_count_q + 1'b1;
			end
			if (take_new) begin
				high_water_q <= high_water_q + 1'b1;
			end
		end
	end

	// Result of the command in flight; error results carry a zero index.
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !q_empty) begin
			reused_q <= 1'b0;
			idx_q    <= '0;
			st_q     <= ST_OK;
			if (!q_cmd.is_free) begin
				if (take_new) begin
					idx_q <= SLOT_W'(high_water_q);
				end else if (exhausted) begin
					st_q <= ST_EXHAUSTED;
				end
			end else if (q_cmd.range_err) begin
				st_q <= ST_RANGE;
			end else if (stack_full) begin
				st_q <= ST_FULL;
			end else begin
				idx_q <= q_cmd.idx;
			end
		end else if (state_q == B_READ) begin
			idx_q    <= SLOT_W'(rd_data_q);
			reused_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= st_q;
			out_idx_q    <= idx_q[IDX_W-1:0];
			out_ofs_q    <= product[OFS_W-1:0];
			out_reused_q <= reused_q;
		end
	end

	assign empty            = !out_valid_q;
	assign status           = out_status_q;
	assign slot_index       = out_idx_q;
	assign slot_byte_offset = out_ofs_q;
	assign reused           = out_reused_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(POOL_CAP))
		else $error("free stack count beyond pool capacity");

	a_hw_cap: assert property (@(posedge clk) disable iff (!arst_n)
		high_water_q <= CNT_W'(POOL_CAP))
		else $error("high-water counter beyond pool capacity");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd && mem_wr))
		else $error("free stack read and written in one cycle");

	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> $past(mem_rd))
		else $error("stack read state entered without a read");

endmodule

FILE: rtl/slot_pool_allocator.sv
// Top level of the slot pool allocator: configuration registers and the
// front end, command queue and back end. Depends on spa_pkg and all rtl modules.
//
// Usage: requests enter as words on a queue-like port (push/full). An allocate
// word hands out the most recently freed slot, or else the next never-used
// slot, or reports the pool exhausted. A free word carries a byte offset that
// is range checked and divided by the element size to give the slot to push
// on the free stack. Every request word gives exactly one result word, read
// through empty/pop; results come out in request order.
// An allocate passes the front end's send state, the queue and the back end's
// multiply state, with a stack read state before it when the slot comes from
// the free stack. A free adds a limit multiply, a compare and a bit-serial
// divider ahead of the send state; the divider is skipped when the offset lies
// past the pool. The front end holds one request at a time and takes no new
// word until it has handed the last one to the queue. Allocates served from
// the free stack hold the back end through its read and multiply states. A
// two-word queue and the result register let the front end keep accepting
// while an earlier result waits. When the consumer stalls, the back end holds
// its finished command and then the queue fills. Reset clears the free stack
// count and high-water counter and sets the pool size to 1024 and the element
// size to 1; there is no memory clearing pass. Configuration writes are always
// ready and are expected only while idle.
module slot_pool_allocator #(
	parameter int MAX_SLOTS          = 1024,
	parameter int MAX_ELEMENT_OCTETS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              req_type,
	input  logic [spa_pkg::OFS_W-1:0]         byte_offset,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        status,
	output logic [spa_pkg::IDX_W-1:0]         slot_index,
	output logic [spa_pkg::OFS_W-1:0]         slot_byte_offset,
	output logic                              reused,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spa_pkg::CFG_W-1:0]         cfg_data
);
	import spa_pkg::*;

	// The pool size register can never exceed what its 11 bits hold, so the
	// stack depth and counters follow the smaller of the two bounds.
	localparam int POOL_MAX = (1 << POOL_W) - 1;
	localparam int OCT_MAX  = (1 << OCT_W) - 1;
	localparam int POOL_CAP = (MAX_SLOTS > POOL_MAX) ? POOL_MAX : MAX_SLOTS;
	localparam int OCT_CAP  = (MAX_ELEMENT_OCTETS > OCT_MAX) ? OCT_MAX : MAX_ELEMENT_OCTETS;
	localparam int CNT_W    = $clog2(POOL_CAP + 1);
	localparam logic [POOL_W-1:0] POOL_CAP_V = POOL_CAP[POOL_W-1:0];
	localparam logic [OCT_W-1:0]  OCT_CAP_V  = OCT_CAP[OCT_W-1:0];

	logic [POOL_W-1:0] pool_entries_q;
	logic [OCT_W-1:0]  element_octets_q;
	logic [CNT_W-1:0]  eff_pool;
	logic [OCT_W-1:0]  eff_oct;

	cmd_t              front_cmd;
	cmd_t              back_cmd;
	logic              front_push;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_entries_q   <= POOL_RESET;
			element_octets_q <= OCT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POOL_ENTRIES:   pool_entries_q   <= cfg_data[POOL_W-1:0];
				REG_ELEMENT_OCTETS: element_octets_q <= cfg_data[OCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate the registers to the supported range; a zero element size acts as one.
	assign eff_pool = (pool_entries_q > POOL_CAP_V) ? CNT_W'(POOL_CAP)
	                                                 : CNT_W'(pool_entries_q);
	assign eff_oct  = (element_octets_q == '0)        ? OCT_W'(1) :
	                  (element_octets_q > OCT_CAP_V)   ? OCT_CAP_V : element_octets_q;

	spa_front #(
		.CNT_W (CNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.byte_offset (byte_offset),
		.eff_pool    (eff_pool),
		.eff_oct     (eff_oct),
		.q_push      (front_push),
		.q_cmd       (front_cmd),
		.q_full      (q_full)
	);

	spa_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (back_cmd),
		.empty   (q_empty)
	);

	spa_back #(
		.POOL_CAP (POOL_CAP)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_cmd            (back_cmd),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.eff_pool         (eff_pool),
		.eff_oct          (eff_oct),
		.empty            (empty),
		.pop              (pop),
		.status           (status),
		.slot_index       (slot_index),
		.slot_byte_offset (slot_byte_offset),
		.reused           (reused)
	);

endmodule
